@@ sv/sstv_rgb_line_tone_sequencer_core_assert.svh @@
// Assertion macros shared by the tone sequencer modules.
`ifndef SSTV_RGB_LINE_TONE_SEQUENCER_CORE_ASSERT_SVH
`define SSTV_RGB_LINE_TONE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication under a synchronous reset
`define SSTVSEQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under a synchronous reset
`define SSTVSEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/sstvseq_pkg.sv @@
package sstvseq_pkg;

   // Line store geometry
   localparam int LINE_MAX    = 1024;
   localparam int LINE_ADDR_W = $clog2(LINE_MAX);
   localparam int WIDTH_W     = LINE_ADDR_W + 1;

   // Tone table geometry
   localparam int TONE_SLOTS   = 8;
   localparam int TONE_INDEX_W = $clog2(TONE_SLOTS);
   localparam int TONE_COUNT_W = 4;
   localparam int ENTRY_W      = 28;
   localparam int PAIR_W       = 2 * ENTRY_W;
   localparam int PAIR_COUNT   = TONE_SLOTS / 2;

   // Payload widths
   localparam int PIXEL_W    = 16;
   localparam int FREQ_W     = 16;
   localparam int DURATION_W = 14;
   localparam int PIX_DUR_W  = 11;
   localparam int LEVEL_W    = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = PAIR_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_PAIR_0      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_PAIR_1      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_PAIR_2      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_PAIR_3      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_COUNT       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_DURATION   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SYNC       = 3'd7;

   // Command codes on the request channel
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_TONE  = 2'd2;

   // Tone table entry types
   localparam logic [1:0] TONE_FIXED = 2'd0;
   localparam logic [1:0] TONE_RED   = 2'd1;
   localparam logic [1:0] TONE_GREEN = 2'd2;
   localparam logic [1:0] TONE_BLUE  = 2'd3;

   // Start sync tone: 1200 Hz for 9 ms
   localparam logic [FREQ_W-1:0]     SYNC_FREQ_X16    = 16'd19200;
   localparam logic [DURATION_W-1:0] SYNC_DURATION_US = 14'd9000;
   localparam int                    SCAN_BASE_X16    = 24000;

   // Front to back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_START,
      OP_TONE
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [PIXEL_W-1:0]   pixel;
   } queue_item_type;

   typedef struct packed {
      logic                 valid;
      queue_item_type       item;
   } queue_head_type;

   typedef struct packed {
      logic [PAIR_COUNT-1:0][PAIR_W-1:0] tone_pair;
      logic [TONE_COUNT_W-1:0]           tone_count;
      logic [PIX_DUR_W-1:0]              pixel_duration;
      logic [WIDTH_W-1:0]                line_width;
      logic                              start_sync_enable;
   } cfg_type;

   typedef logic [FREQ_W-1:0] scan_table_type [2**LEVEL_W];

   // Level 0..255 onto 1500..2300 Hz in 1/16 Hz, halves rounded up
   function automatic scan_table_type build_scan_table();
      scan_table_type t;
      for (int i = 0; i < 2**LEVEL_W; i++) begin
         t[i] = FREQ_W'(SCAN_BASE_X16 + (i * 12800 + 127) / 255);
      end
      return t;
   endfunction

   localparam scan_table_type SCAN_FREQ_TABLE = build_scan_table();

endpackage

@@ sv/sstvseq_if.sv @@
// Request channel: command and pixel
interface sstvseq_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        command;
   logic [sstvseq_pkg::PIXEL_W-1:0]   pixel;

   modport source (output valid, output command, output pixel, input ready);
   modport sink   (input valid, input command, input pixel, output ready);
endinterface

// Result channel: one tone per next-tone command
interface sstvseq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [sstvseq_pkg::FREQ_W-1:0]       frequency_x16;
   logic [sstvseq_pkg::DURATION_W-1:0]   duration_us;
   logic                                 line_done;

   modport source (output valid, output frequency_x16, output duration_us,
                   output line_done, input ready);
   modport sink   (input valid, input frequency_x16, input duration_us,
                   input line_done, output ready);
endinterface

@@ sv/sstvseq_front.sv @@
`include "sstv_rgb_line_tone_sequencer_core_assert.svh"

module sstvseq_front (
   input  logic                         clock,
   input  logic                         reset,
   sstvseq_req_if.sink                  req_if,
   input  logic                         pop,
   output sstvseq_pkg::queue_head_type  head
);

   sstvseq_pkg::queue_item_type                 queue_ff [sstvseq_pkg::QUEUE_DEPTH];
   logic [sstvseq_pkg::QUEUE_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [sstvseq_pkg::QUEUE_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [sstvseq_pkg::QUEUE_CNT_W-1:0]         count_ff, count_in;
   sstvseq_pkg::op_type                         op;
   logic                                        cmd_known;
   logic                                        push;

   // Classify the command; unknown codes are taken and dropped
   always_comb begin
      op        = sstvseq_pkg::OP_LOAD;
      cmd_known = 1'b1;
      unique case (req_if.command)
         sstvseq_pkg::CMD_LOAD:  op = sstvseq_pkg::OP_LOAD;
         sstvseq_pkg::CMD_START: op = sstvseq_pkg::OP_START;
         sstvseq_pkg::CMD_TONE:  op = sstvseq_pkg::OP_TONE;
         default:                cmd_known = 1'b0;
      endcase
   end

   assign req_if.ready = (count_ff != sstvseq_pkg::QUEUE_CNT_W'(sstvseq_pkg::QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready && cmd_known;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{op: op, pixel: req_if.pixel};
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   `SSTVSEQ_ASSERT_IMPL(a_pop_needs_item, clock, reset, pop, count_ff != '0, "pop from empty queue")
   `SSTVSEQ_ASSERT_NEXT(a_push_counts, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1, "queue count lost a push")

endmodule

@@ sv/sstvseq_back.sv @@
`include "sstv_rgb_line_tone_sequencer_core_assert.svh"

module sstvseq_back (
   input  logic                         clock,
   input  logic                         reset,
   input  sstvseq_pkg::cfg_type         cfg,
   input  sstvseq_pkg::queue_head_type  head,
   output logic                         pop,
   sstvseq_rsp_if.source                rsp_if
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                                   state_ff, state_in;
   logic [sstvseq_pkg::LINE_ADDR_W-1:0]         write_index_ff, write_index_in;
   logic [sstvseq_pkg::TONE_INDEX_W-1:0]        tone_index_ff, tone_index_in;
   logic [sstvseq_pkg::LINE_ADDR_W-1:0]         pixel_index_ff, pixel_index_in;
   logic                                        sync_pending_ff, sync_pending_in;
   logic [1:0]                                  scan_type_ff, scan_type_in;
   logic                                        out_valid_ff;
   logic [sstvseq_pkg::FREQ_W-1:0]              out_freq_ff;
   logic [sstvseq_pkg::DURATION_W-1:0]          out_dur_ff;
   logic                                        out_done_ff;

   logic [sstvseq_pkg::PIXEL_W-1:0]             line_store [sstvseq_pkg::LINE_MAX];
   logic [sstvseq_pkg::PIXEL_W-1:0]             rd_data_ff;
   logic                                        mem_we;
   logic                                        rd_issue;

   logic [sstvseq_pkg::PAIR_W-1:0]              pair;
   logic [sstvseq_pkg::ENTRY_W-1:0]             entry;
   logic [1:0]                                  entry_type;
   logic [sstvseq_pkg::TONE_COUNT_W-1:0]        eff_count;
   logic [sstvseq_pkg::WIDTH_W-1:0]             eff_width;
   logic [sstvseq_pkg::TONE_COUNT_W-1:0]        tone_next;
   logic [sstvseq_pkg::WIDTH_W-1:0]             pix_next;
   logic                                        tone_end;
   logic                                        pix_end;
   logic                                        out_free;
   logic [sstvseq_pkg::LEVEL_W-1:0]             level;

   logic                                        emit;
   logic [sstvseq_pkg::FREQ_W-1:0]              emit_freq;
   logic [sstvseq_pkg::DURATION_W-1:0]          emit_dur;
   logic                                        emit_done;

   // Select the current table entry
   assign pair       = cfg.tone_pair[tone_index_ff[sstvseq_pkg::TONE_INDEX_W-1:1]];
   assign entry      = tone_index_ff[0] ? pair[sstvseq_pkg::PAIR_W-1:sstvseq_pkg::ENTRY_W]
                                        : pair[sstvseq_pkg::ENTRY_W-1:0];
   assign entry_type = entry[27:26];

   // Clamp entry count and line width into range
   always_comb begin
      if (cfg.tone_count == '0) begin
         eff_count = sstvseq_pkg::TONE_COUNT_W'(1);
      end else if (cfg.tone_count > sstvseq_pkg::TONE_COUNT_W'(sstvseq_pkg::TONE_SLOTS)) begin
         eff_count = sstvseq_pkg::TONE_COUNT_W'(sstvseq_pkg::TONE_SLOTS);
      end else begin
         eff_count = cfg.tone_count;
      end
      if (cfg.line_width == '0) begin
         eff_width = sstvseq_pkg::WIDTH_W'(1);
      end else if (cfg.line_width > sstvseq_pkg::WIDTH_W'(sstvseq_pkg::LINE_MAX)) begin
         eff_width = sstvseq_pkg::WIDTH_W'(sstvseq_pkg::LINE_MAX);
      end else begin
         eff_width = cfg.line_width;
      end
   end

   assign tone_next = {1'b0, tone_index_ff} + 1'b1;
   assign pix_next  = {1'b0, pixel_index_ff} + 1'b1;
   assign tone_end  = (tone_next >= eff_count);
   assign pix_end   = (pix_next >= eff_width);
   assign out_free  = !out_valid_ff || rsp_if.ready;

   // Expand the stored pixel component to an 8-bit level
   always_comb begin
      case (scan_type_ff)
         sstvseq_pkg::TONE_RED:   level = {rd_data_ff[15:11], 3'b000};
         sstvseq_pkg::TONE_GREEN: level = {rd_data_ff[10:5], 2'b00};
         sstvseq_pkg::TONE_BLUE:  level = {rd_data_ff[4:0], 3'b000};
         default:                 level = '0;
      endcase
   end

   // Sequence one queued item
   always_comb begin
      state_in        = state_ff;
      write_index_in  = write_index_ff;
      tone_index_in   = tone_index_ff;
      pixel_index_in  = pixel_index_ff;
      sync_pending_in = sync_pending_ff;
      scan_type_in    = scan_type_ff;
      pop             = 1'b0;
      mem_we          = 1'b0;
      rd_issue        = 1'b0;
      emit            = 1'b0;
      emit_freq       = '0;
      emit_dur        = '0;
      emit_done       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               unique case (head.item.op)
                  sstvseq_pkg::OP_LOAD: begin
                     pop            = 1'b1;
                     mem_we         = 1'b1;
                     write_index_in = write_index_ff + 1'b1;
                  end
                  sstvseq_pkg::OP_START: begin
                     pop             = 1'b1;
                     tone_index_in   = '0;
                     pixel_index_in  = '0;
                     write_index_in  = '0;
                     sync_pending_in = cfg.start_sync_enable;
                  end
                  sstvseq_pkg::OP_TONE: begin
                     if (out_free) begin
                        pop = 1'b1;
                        if (sync_pending_ff) begin
                           emit            = 1'b1;
                           emit_freq       = sstvseq_pkg::SYNC_FREQ_X16;
                           emit_dur        = sstvseq_pkg::SYNC_DURATION_US;
                           sync_pending_in = 1'b0;
                        end else if (entry_type == sstvseq_pkg::TONE_FIXED) begin
                           emit           = 1'b1;
                           emit_freq      = {entry[11:0], 4'b0000};
                           emit_dur       = entry[25:12];
                           emit_done      = tone_end;
                           pixel_index_in = '0;
                           tone_index_in  = tone_end ? '0 : tone_next[sstvseq_pkg::TONE_INDEX_W-1:0];
                           if (tone_end) begin
                              write_index_in = '0;
                           end
                        end else begin
                           rd_issue     = 1'b1;
                           scan_type_in = entry_type;
                           state_in     = ST_SCAN;
                        end
                     end
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_freq = sstvseq_pkg::SCAN_FREQ_TABLE[level];
               emit_dur  = sstvseq_pkg::DURATION_W'(cfg.pixel_duration);
               if (pix_end) begin
                  emit_done      = tone_end;
                  pixel_index_in = '0;
                  tone_index_in  = tone_end ? '0 : tone_next[sstvseq_pkg::TONE_INDEX_W-1:0];
                  if (tone_end) begin
                     write_index_in = '0;
                  end
               end else begin
                  pixel_index_in = pix_next[sstvseq_pkg::LINE_ADDR_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state, indexes and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         write_index_ff  <= '0;
         tone_index_ff   <= '0;
         pixel_index_ff  <= '0;
         sync_pending_ff <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         write_index_ff  <= write_index_in;
         tone_index_ff   <= tone_index_in;
         pixel_index_ff  <= pixel_index_in;
         sync_pending_ff <= sync_pending_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      scan_type_ff <= scan_type_in;
      if (emit) begin
         out_freq_ff <= emit_freq;
         out_dur_ff  <= emit_dur;
         out_done_ff <= emit_done;
      end
   end

   // Line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store[write_index_ff] <= head.item.pixel;
      end
      if (rd_issue) begin
         rd_data_ff <= line_store[pixel_index_ff];
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.frequency_x16 = out_freq_ff;
   assign rsp_if.duration_us   = out_dur_ff;
   assign rsp_if.line_done     = out_done_ff;

   `SSTVSEQ_ASSERT_IMPL(a_no_overwrite, clock, reset, out_valid_ff && !rsp_if.ready, !emit, "result overwritten while stalled")
   `SSTVSEQ_ASSERT_NEXT(a_line_end_rewinds, clock, reset, emit && emit_done, tone_index_ff == '0 && pixel_index_ff == '0 && write_index_ff == '0, "line end did not rewind")
   `SSTVSEQ_ASSERT_NEXT(a_sync_once, clock, reset, emit && sync_pending_ff && state_ff == ST_IDLE, !sync_pending_ff && !out_done_ff && out_dur_ff == sstvseq_pkg::SYNC_DURATION_US, "start sync not taken once")

endmodule

@@ sv/sstv_rgb_line_tone_sequencer_core.sv @@
// SSTV RGB line tone sequencer. Load a line of RGB565 pixels with load
// commands, then issue one next-tone command per tone; each returns the
// frequency in 1/16 Hz, the duration in microseconds and a line-done flag
// on the last tone of the line. A frame start clears the line position and,
// with start sync enabled, makes the next tone a 9 ms 1200 Hz sync. Items
// pass through a two-entry queue into the sequencer: a load, a frame start,
// the sync or a fixed table tone is handled in the idle state; a scanned
// pixel tone also passes the scan state, for the registered read of the
// 1024 x 16 line store. A result is registered in an output register as its
// tone is emitted and waits there, so new items keep entering while it is
// stalled. Write the registers only while idle.
module sstv_rgb_line_tone_sequencer_core (
   input  logic                                   clock,
   input  logic                                   reset,
   sstvseq_req_if.sink                            req_if,
   sstvseq_rsp_if.source                          rsp_if,
   input  logic                                   csr_write_enable,
   input  logic [sstvseq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sstvseq_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   sstvseq_pkg::cfg_type         cfg_ff;
   sstvseq_pkg::queue_head_type  head;
   logic                         pop;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tone_pair         <= '0;
         cfg_ff.tone_count        <= sstvseq_pkg::TONE_COUNT_W'(7);
         cfg_ff.pixel_duration    <= sstvseq_pkg::PIX_DUR_W'(432);
         cfg_ff.line_width        <= sstvseq_pkg::WIDTH_W'(320);
         cfg_ff.start_sync_enable <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sstvseq_pkg::CSR_TONE_PAIR_0:    cfg_ff.tone_pair[0] <= csr_write_data;
            sstvseq_pkg::CSR_TONE_PAIR_1:    cfg_ff.tone_pair[1] <= csr_write_data;
            sstvseq_pkg::CSR_TONE_PAIR_2:    cfg_ff.tone_pair[2] <= csr_write_data;
            sstvseq_pkg::CSR_TONE_PAIR_3:    cfg_ff.tone_pair[3] <= csr_write_data;
            sstvseq_pkg::CSR_TONE_COUNT:
               cfg_ff.tone_count <= csr_write_data[sstvseq_pkg::TONE_COUNT_W-1:0];
            sstvseq_pkg::CSR_PIXEL_DURATION:
               cfg_ff.pixel_duration <= csr_write_data[sstvseq_pkg::PIX_DUR_W-1:0];
            sstvseq_pkg::CSR_LINE_WIDTH:
               cfg_ff.line_width <= csr_write_data[sstvseq_pkg::WIDTH_W-1:0];
            sstvseq_pkg::CSR_START_SYNC:
               cfg_ff.start_sync_enable <= csr_write_data[0];
         endcase
      end
   end

   sstvseq_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .pop    (pop),
      .head   (head)
   );

   sstvseq_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

@@ test/tb_sstv_rgb_line_tone_sequencer_core.sv @@
`timescale 1ns / 100ps

module tb_sstv_rgb_line_tone_sequencer_core;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int NUM_PHASES   = 12;
   localparam int PHASE_ITEMS  = 150;
   localparam int IDLE_CYCLES  = 12;
   localparam int END_CYCLES   = 20;
   localparam int RESET_ROWS   = 6;
   localparam int STEP_ROWS    = 18;

   typedef struct packed {
      logic [sstvseq_pkg::FREQ_W-1:0]     freq;
      logic [sstvseq_pkg::DURATION_W-1:0] dur;
      logic                               done;
   } tone_type;

   typedef struct packed {
      logic [1:0]                      cmd;
      logic [sstvseq_pkg::PIXEL_W-1:0] pix;
      logic                            typed;
      tone_type                        want;
   } step_type;

   // Rows below RESET_ROWS run under the reset mode; the rest under the directed mode
   localparam step_type DIRECTED_STEPS [STEP_ROWS] = '{
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b1, '{16'd0, 14'd0, 1'b0}},
      '{sstvseq_pkg::CMD_START, 16'h0000, 1'b0, '{16'd0, 14'd0, 1'b0}},
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b1,
        '{sstvseq_pkg::SYNC_FREQ_X16, sstvseq_pkg::SYNC_DURATION_US, 1'b0}},
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b1, '{16'd0, 14'd0, 1'b0}},
      '{CMD_UNUSED,             16'hFFFF, 1'b0, '{16'd0, 14'd0, 1'b0}},
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b1, '{16'd0, 14'd0, 1'b0}},
      '{sstvseq_pkg::CMD_START, 16'h0000, 1'b0, '{16'd0, 14'd0, 1'b0}},
      '{sstvseq_pkg::CMD_LOAD,  16'hFFFF, 1'b0, '{16'd0, 14'd0, 1'b0}},
      '{sstvseq_pkg::CMD_LOAD,  16'h0000, 1'b0, '{16'd0, 14'd0, 1'b0}},
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b1, '{16'd65520, 14'd16383, 1'b0}},
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b0, '{16'd0, 14'd0, 1'b0}},
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b1, '{16'd24000, 14'd2047, 1'b0}},
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b0, '{16'd0, 14'd0, 1'b0}},
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b1, '{16'd24000, 14'd2047, 1'b0}},
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b0, '{16'd0, 14'd0, 1'b0}},
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b1, '{16'd24000, 14'd2047, 1'b0}},
      '{sstvseq_pkg::CMD_TONE,  16'h0000, 1'b1, '{16'd0, 14'd0, 1'b1}},
      '{CMD_UNUSED,             16'h0000, 1'b0, '{16'd0, 14'd0, 1'b0}}
   };

   logic                                clock;
   logic                                reset;
   logic                                csr_write_enable;
   logic [sstvseq_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sstvseq_pkg::CSR_DATA_W-1:0]  csr_write_data;

   sstvseq_req_if req_ch ();
   sstvseq_rsp_if rsp_ch ();

   sstv_rgb_line_tone_sequencer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Mirror of the mode registers
   logic [sstvseq_pkg::PAIR_W-1:0]       mode_pair [sstvseq_pkg::PAIR_COUNT];
   logic [sstvseq_pkg::TONE_COUNT_W-1:0] mode_tone_count;
   logic [sstvseq_pkg::PIX_DUR_W-1:0]    mode_pixel_dur;
   logic [sstvseq_pkg::WIDTH_W-1:0]      mode_line_width;
   logic                                 mode_sync_enable;

   // Mirror of the line position and line store
   logic [sstvseq_pkg::PIXEL_W-1:0] line_copy [sstvseq_pkg::LINE_MAX];
   bit                              line_written [sstvseq_pkg::LINE_MAX];
   int unsigned                     load_idx;
   int unsigned                     tone_idx;
   int unsigned                     pix_idx;
   bit                              sync_due;

   tone_type    pending_tones [$];
   tone_type    oldest;
   int unsigned items_sent;
   int unsigned tones_seen;
   int unsigned errors;
   bit          no_stall;

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_stall || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [sstvseq_pkg::PIXEL_W-1:0] random_pixel();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return sstvseq_pkg::PIXEL_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [sstvseq_pkg::ENTRY_W-1:0] random_entry();
      int unsigned r;
      logic [1:0]  kind;
      logic [13:0] dur;
      logic [11:0] freq;
      r = $urandom_range(0, 9);
      kind = (r < 5) ? sstvseq_pkg::TONE_FIXED : 2'($urandom_range(1, 3));
      dur = (r == 4) ? 14'd0 : 14'($urandom_range(0, 16383));
      freq = 12'($urandom_range(0, 4095));
      return {kind, dur, freq};
   endfunction

   function automatic logic [sstvseq_pkg::ENTRY_W-1:0] table_entry(input int unsigned idx);
      if (idx >= sstvseq_pkg::TONE_SLOTS) return '0;
      return mode_pair[idx / 2][(idx % 2) * sstvseq_pkg::ENTRY_W +: sstvseq_pkg::ENTRY_W];
   endfunction

   function automatic int unsigned used_entries();
      int unsigned c;
      c = mode_tone_count;
      if (c < 1) c = 1;
      if (c > sstvseq_pkg::TONE_SLOTS) c = sstvseq_pkg::TONE_SLOTS;
      return c;
   endfunction

   function automatic int unsigned used_pixels();
      int unsigned w;
      w = mode_line_width;
      if (w < 1) w = 1;
      if (w > sstvseq_pkg::LINE_MAX) w = sstvseq_pkg::LINE_MAX;
      return w;
   endfunction

   // Step to the next table entry; report the end of the line
   function automatic bit next_entry();
      tone_idx++;
      pix_idx = 0;
      if (tone_idx >= used_entries()) begin
         tone_idx = 0;
         load_idx = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // A tone request now would scan a store entry never loaded
   function automatic bit scan_unwritten();
      logic [sstvseq_pkg::ENTRY_W-1:0] e;
      e = table_entry(tone_idx);
      return !sync_due && e[27:26] != sstvseq_pkg::TONE_FIXED &&
             !line_written[pix_idx % sstvseq_pkg::LINE_MAX];
   endfunction

   // Apply one item to the mirror; return 1 with the tone it produces
   function automatic bit predict_tone(input logic [1:0] cmd,
                                       input logic [sstvseq_pkg::PIXEL_W-1:0] pix,
                                       output tone_type t);
      logic [sstvseq_pkg::ENTRY_W-1:0] e;
      logic [sstvseq_pkg::PIXEL_W-1:0] p;
      int unsigned                     level;
      t = '0;
      case (cmd)
         sstvseq_pkg::CMD_LOAD: begin
            line_copy[load_idx] = pix;
            line_written[load_idx] = 1'b1;
            load_idx = (load_idx + 1) % sstvseq_pkg::LINE_MAX;
            return 1'b0;
         end
         sstvseq_pkg::CMD_START: begin
            tone_idx = 0;
            pix_idx = 0;
            load_idx = 0;
            sync_due = mode_sync_enable;
            return 1'b0;
         end
         sstvseq_pkg::CMD_TONE: ;
         default: return 1'b0;
      endcase
      if (sync_due) begin
         sync_due = 1'b0;
         t.freq = sstvseq_pkg::SYNC_FREQ_X16;
         t.dur = sstvseq_pkg::SYNC_DURATION_US;
         return 1'b1;
      end
      e = table_entry(tone_idx);
      if (e[27:26] == sstvseq_pkg::TONE_FIXED) begin
         t.freq = {e[11:0], 4'b0000};
         t.dur = e[25:12];
         t.done = next_entry();
      end else begin
         p = line_copy[pix_idx % sstvseq_pkg::LINE_MAX];
         case (e[27:26])
            sstvseq_pkg::TONE_RED:   level = {p[15:11], 3'b000};
            sstvseq_pkg::TONE_GREEN: level = {p[10:5], 2'b00};
            default:                 level = {p[4:0], 3'b000};
         endcase
         t.freq = sstvseq_pkg::FREQ_W'(sstvseq_pkg::SCAN_BASE_X16 + (level * 12800 + 127) / 255);
         t.dur = sstvseq_pkg::DURATION_W'(mode_pixel_dur);
         pix_idx++;
         t.done = (pix_idx >= used_pixels()) ? next_entry() : 1'b0;
      end
      return 1'b1;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Drive one item and hold it until the block takes it
   task automatic send_item(input logic [1:0] cmd, input logic [sstvseq_pkg::PIXEL_W-1:0] pix);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.pixel <= pix;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Send an item, record its tone, and tell whether the line ended
   task automatic issue(input logic [1:0] cmd, input logic [sstvseq_pkg::PIXEL_W-1:0] pix,
                        output bit line_end);
      tone_type                        t;
      bit                              has;
      logic [1:0]                      c;
      logic [sstvseq_pkg::PIXEL_W-1:0] v;
      c = cmd;
      v = pix;
      if (c == sstvseq_pkg::CMD_TONE && scan_unwritten()) begin
         c = sstvseq_pkg::CMD_LOAD;
         v = random_pixel();
      end
      send_item(c, v);
      has = predict_tone(c, v, t);
      if (has) pending_tones.push_back(t);
      line_end = has && t.done;
      if (c != CMD_UNUSED) items_sent++;
   endtask

   // Drop valid and wait until every expected tone has arrived
   task automatic drain_tones(input int unsigned extra);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_tones.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sstvseq_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sstvseq_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         sstvseq_pkg::CSR_TONE_PAIR_0:    mode_pair[0] = value;
         sstvseq_pkg::CSR_TONE_PAIR_1:    mode_pair[1] = value;
         sstvseq_pkg::CSR_TONE_PAIR_2:    mode_pair[2] = value;
         sstvseq_pkg::CSR_TONE_PAIR_3:    mode_pair[3] = value;
         sstvseq_pkg::CSR_TONE_COUNT:
            mode_tone_count = value[sstvseq_pkg::TONE_COUNT_W-1:0];
         sstvseq_pkg::CSR_PIXEL_DURATION:
            mode_pixel_dur = value[sstvseq_pkg::PIX_DUR_W-1:0];
         sstvseq_pkg::CSR_LINE_WIDTH:
            mode_line_width = value[sstvseq_pkg::WIDTH_W-1:0];
         default:                         mode_sync_enable = value[0];
      endcase
   endtask

   task automatic program_mode(input logic [sstvseq_pkg::PAIR_W-1:0] p0,
                               input logic [sstvseq_pkg::PAIR_W-1:0] p1,
                               input logic [sstvseq_pkg::PAIR_W-1:0] p2,
                               input logic [sstvseq_pkg::PAIR_W-1:0] p3,
                               input int unsigned count, input int unsigned pdur,
                               input int unsigned width, input bit sync);
      write_csr(sstvseq_pkg::CSR_TONE_PAIR_0, p0);
      write_csr(sstvseq_pkg::CSR_TONE_PAIR_1, p1);
      write_csr(sstvseq_pkg::CSR_TONE_PAIR_2, p2);
      write_csr(sstvseq_pkg::CSR_TONE_PAIR_3, p3);
      write_csr(sstvseq_pkg::CSR_TONE_COUNT, sstvseq_pkg::CSR_DATA_W'(count));
      write_csr(sstvseq_pkg::CSR_PIXEL_DURATION, sstvseq_pkg::CSR_DATA_W'(pdur));
      write_csr(sstvseq_pkg::CSR_LINE_WIDTH, sstvseq_pkg::CSR_DATA_W'(width));
      write_csr(sstvseq_pkg::CSR_START_SYNC, sstvseq_pkg::CSR_DATA_W'(sync));
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly whole lines with random pixels, the rest noise and broken lines
   task automatic run_phase(input int unsigned budget);
      int unsigned first;
      int unsigned n;
      bit          done;
      bit          paused;
      first = items_sent;
      paused = 1'b0;
      while (items_sent - first < budget) begin
         if (!paused && items_sent - first >= budget / 2) begin
            drain_tones(0);
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 75) begin
            if ($urandom_range(0, 1) == 1) issue(sstvseq_pkg::CMD_START, random_pixel(), done);
            n = used_pixels();
            for (int i = 0; i < n && items_sent - first < budget; i++)
               issue(sstvseq_pkg::CMD_LOAD, random_pixel(), done);
            done = 1'b0;
            while (!done && items_sent - first < budget)
               issue(sstvseq_pkg::CMD_TONE, random_pixel(), done);
         end else begin
            n = $urandom_range(1, 8);
            repeat (n) issue(2'($urandom_range(0, 3)), random_pixel(), done);
         end
      end
   endtask

   // Result side: random stalls, none in quiet phases
   initial begin
      int unsigned on_len;
      int unsigned off_len;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         on_len = $urandom_range(1, 24);
         repeat (on_len) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end
         off_len = pick_gap();
         repeat (off_len) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   // Check each tone against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tones_seen++;
         if (pending_tones.size() == 0) begin
            $error("unexpected tone: frequency_x16 %0d duration_us %0d line_done %0d",
                   rsp_ch.frequency_x16, rsp_ch.duration_us, rsp_ch.line_done);
            errors++;
         end else begin
            oldest = pending_tones.pop_front();
            if (rsp_ch.frequency_x16 !== oldest.freq) begin
               $error("frequency_x16 expected %0d got %0d", oldest.freq, rsp_ch.frequency_x16);
               errors++;
            end
            if (rsp_ch.duration_us !== oldest.dur) begin
               $error("duration_us expected %0d got %0d", oldest.dur, rsp_ch.duration_us);
               errors++;
            end
            if (rsp_ch.line_done !== oldest.done) begin
               $error("line_done expected %0d got %0d", oldest.done, rsp_ch.line_done);
               errors++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      tone_type                       t;
      bit                             has;
      logic [sstvseq_pkg::PAIR_W-1:0] pairs [sstvseq_pkg::PAIR_COUNT];
      int unsigned                    count;
      int unsigned                    width;
      int unsigned                    pdur;
      bit                             sync;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = sstvseq_pkg::CMD_LOAD;
      req_ch.pixel = '0;
      csr_write_enable = 1'b0;
      csr_index = sstvseq_pkg::CSR_TONE_PAIR_0;
      csr_write_data = '0;
      no_stall = 1'b0;
      items_sent = 0;
      tones_seen = 0;
      errors = 0;
      foreach (mode_pair[k]) mode_pair[k] = '0;
      mode_tone_count = 4'd7;
      mode_pixel_dur = 11'd432;
      mode_line_width = 11'd320;
      mode_sync_enable = 1'b1;
      load_idx = 0;
      tone_idx = 0;
      pix_idx = 0;
      sync_due = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed steps: reset mode first, then a hand-made mode
      for (int i = 0; i < STEP_ROWS; i++) begin
         if (i == RESET_ROWS) begin
            drain_tones(IDLE_CYCLES);
            program_mode({sstvseq_pkg::TONE_FIXED, 14'd0, 12'd0,
                          sstvseq_pkg::TONE_FIXED, 14'd16383, 12'd4095} ^
                         {sstvseq_pkg::TONE_RED, 14'd100, 12'd1000, 28'd0},
                         {sstvseq_pkg::TONE_BLUE, 14'd300, 12'd1200,
                          sstvseq_pkg::TONE_GREEN, 14'd200, 12'd1100},
                         {sstvseq_pkg::TONE_FIXED, 14'd5, 12'd5,
                          sstvseq_pkg::TONE_FIXED, 14'd0, 12'd0},
                         {sstvseq_pkg::TONE_FIXED, 14'd5, 12'd5,
                          sstvseq_pkg::TONE_FIXED, 14'd5, 12'd5},
                         5, 2047, 2, 1'b0);
         end
         send_item(DIRECTED_STEPS[i].cmd, DIRECTED_STEPS[i].pix);
         has = predict_tone(DIRECTED_STEPS[i].cmd, DIRECTED_STEPS[i].pix, t);
         if (has) pending_tones.push_back(DIRECTED_STEPS[i].typed ? DIRECTED_STEPS[i].want : t);
         if (DIRECTED_STEPS[i].cmd != CMD_UNUSED) items_sent++;
      end

      // Random phases, each under its own mode with the extremes spread among them
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_tones(IDLE_CYCLES);
         foreach (pairs[k]) pairs[k] = {random_entry(), random_entry()};
         if (ph == 3) foreach (pairs[k]) pairs[k] = '1;
         if (ph == 7) foreach (pairs[k]) pairs[k] = '0;
         case (ph)
            1:       count = 0;
            2:       count = 15;
            3:       count = 8;
            4:       count = 1;
            default: count = $urandom_range(1, 8);
         endcase
         case (ph)
            1:       width = 0;
            2:       width = 2047;
            4:       width = 1;
            5:       width = 1024;
            default: width = $urandom_range(1, 6);
         endcase
         case (ph)
            3:       pdur = 0;
            4:       pdur = 2047;
            6:       pdur = 1;
            default: pdur = $urandom_range(0, 2047);
         endcase
         sync = (ph == 0) ? 1'b1 : 1'($urandom_range(0, 1));
         no_stall = (ph % 4 == 3);
         program_mode(pairs[0], pairs[1], pairs[2], pairs[3], count, pdur, width, sync);
         run_phase(PHASE_ITEMS);
      end
      no_stall = 1'b0;

      drain_tones(END_CYCLES);
      $display("Sent %0d items and checked %0d tones over %0d modes,", items_sent, tones_seen,
               NUM_PHASES + 2);
      $display("including sync, fixed, zero-length and scanned tones and mid-line mode changes.");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #12000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
